// ===== hw/rtl/pti_pkg.sv =====
package pti_pkg;

  localparam int unsigned ANG_W = 19;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned TRIG_W = 18;
  localparam int unsigned Q30_W = 34;
  localparam int unsigned NUM_W = 67;
  localparam int unsigned QUO_W = 36;
  localparam int unsigned TABLE_LEN = 32;

  localparam logic signed [ANG_W-1:0] ANG_LIMIT = 19'sd205887;
  localparam logic signed [Q30_W-1:0] Q30_ONE = 34'sd1073741824;
  localparam logic signed [Q30_W-1:0] Q30_PI = 34'sd3373259426;
  localparam logic signed [Q30_W-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [Q30_W-1:0] Q30_GAIN = 34'sd652032874;

  typedef logic signed [Q30_W-1:0] q30_t;

  typedef struct packed {
    logic                     zero;
    logic signed [ANG_W-1:0]  ang;
    logic signed [RATE_W-1:0] dx;
    logic signed [RATE_W-1:0] dy;
  } item_t;

  function automatic logic signed [Q30_W-1:0] atan_q30(input int unsigned i);
    logic signed [Q30_W-1:0] t;
    unique case (i)
      0: t = 34'sh3243F6A8;  1: t = 34'sh1DAC6705;  2: t = 34'sh0FADBAFC;
      3: t = 34'sh07F56EA6;  4: t = 34'sh03FEAB76;  5: t = 34'sh01FFD55B;
      6: t = 34'sh00FFFAAA;  7: t = 34'sh007FFF55;  8: t = 34'sh003FFFEA;
      9: t = 34'sh001FFFFD;  10: t = 34'sh000FFFFF; 11: t = 34'sh0007FFFF;
      12: t = 34'sh0003FFFF; 13: t = 34'sh0001FFFF; 14: t = 34'sh0000FFFF;
      15: t = 34'sh00007FFF; 16: t = 34'sh00003FFF; 17: t = 34'sh00001FFF;
      18: t = 34'sh00000FFF; 19: t = 34'sh000007FF; 20: t = 34'sh000003FF;
      21: t = 34'sh000001FF; 22: t = 34'sh000000FF; 23: t = 34'sh0000007F;
      24: t = 34'sh0000003F; 25: t = 34'sh0000001F; 26: t = 34'sh0000000F;
      27: t = 34'sh00000008; 28: t = 34'sh00000004; 29: t = 34'sh00000002;
      30: t = 34'sh00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/planar_twist_integrator_core.sv =====
// channel | valid/ready         | payload
// in      | in_valid/in_ready   | angular_rate, rate_x, rate_y
// out     | out_valid/out_ready | cos_theta, sin_theta, trans_x, trans_y
//
// one item a cycle while the output is not stalled
// (cordic stages beyond 32 are not built)
// depth set by the cordic stages and the bit-per-stage divider pipeline
// synchronous reset clears all valid bits; payload registers hold no reset
// the whole pipe advances when the output stage is empty or taken, so a
// stall freezes every stage and loses nothing
module planar_twist_integrator_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [18:0]  angular_rate,
  input  logic signed [31:0]  rate_x,
  input  logic signed [31:0]  rate_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  cos_theta,
  output logic signed [17:0]  sin_theta,
  output logic signed [31:0]  trans_x,
  output logic signed [31:0]  trans_y
);

  localparam int unsigned NS = (CORDIC_STAGES < pti_pkg::TABLE_LEN) ?
                               CORDIC_STAGES : pti_pkg::TABLE_LEN;
  localparam int unsigned TAG_W = 1 + pti_pkg::RATE_W * 2 + pti_pkg::TRIG_W * 2;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: clamp, quadrant fold
  logic                 v0, n0;
  pti_pkg::item_t       it0;
  pti_pkg::q30_t        z0;
  logic signed [18:0]   ac;
  pti_pkg::q30_t        zr;
  assign ac = (angular_rate > pti_pkg::ANG_LIMIT) ? pti_pkg::ANG_LIMIT :
              (angular_rate < -pti_pkg::ANG_LIMIT) ? -pti_pkg::ANG_LIMIT : angular_rate;
  assign zr = pti_pkg::q30_t'(ac) <<< 14;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it0.zero <= (ac == '0);
      it0.ang  <= ac;
      it0.dx   <= rate_x;
      it0.dy   <= rate_y;
      if (zr > pti_pkg::Q30_HALF_PI) begin
        z0 <= zr - pti_pkg::Q30_PI; n0 <= 1'b1;
      end else if (zr < -pti_pkg::Q30_HALF_PI) begin
        z0 <= zr + pti_pkg::Q30_PI; n0 <= 1'b1;
      end else begin
        z0 <= zr; n0 <= 1'b0;
      end
    end
  end

  // cordic, one micro-rotation a stage
  logic [NS:0]     cv;
  pti_pkg::q30_t   cx [NS+1];
  pti_pkg::q30_t   cy [NS+1];
  pti_pkg::q30_t   cz [NS+1];
  logic            cn [NS+1];
  pti_pkg::item_t  ci [NS+1];
  assign cv[0] = v0;
  assign cx[0] = pti_pkg::Q30_GAIN;
  assign cy[0] = '0;
  assign cz[0] = z0;
  assign cn[0] = n0;
  assign ci[0] = it0;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (en) cv[i+1] <= cv[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cn[i+1] <= cn[i];
        ci[i+1] <= ci[i];
        if (!cz[i][pti_pkg::Q30_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - pti_pkg::atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + pti_pkg::atan_q30(i);
        end
      end
    end
  end

  // fold back, round trig, form cos-1
  logic           v1;
  pti_pkg::item_t it1;
  pti_pkg::q30_t  y1, cm1;
  logic signed [17:0] c1, s1;
  pti_pkg::q30_t  xf, yf;
  logic signed [pti_pkg::Q30_W-15:0] cr, sr;
  assign xf = cn[NS] ? -cx[NS] : cx[NS];
  assign yf = cn[NS] ? -cy[NS] : cy[NS];
  assign cr = (pti_pkg::Q30_W-14)'((xf + 34'sd8192) >>> 14);
  assign sr = (pti_pkg::Q30_W-14)'((yf + 34'sd8192) >>> 14);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= cv[NS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= ci[NS];
      y1  <= yf;
      cm1 <= xf - pti_pkg::Q30_ONE;
      c1  <= (cr > 20'sd65536) ? 18'sd65536 : (cr < -20'sd65536) ? -18'sd65536 : 18'(cr);
      s1  <= (sr > 20'sd65536) ? 18'sd65536 : (sr < -20'sd65536) ? -18'sd65536 : 18'(sr);
    end
  end

  // products, registered
  logic           v2;
  pti_pkg::item_t it2;
  logic signed [17:0] c2, s2;
  logic signed [65:0] p_cy, p_sx, p_sy, p_cx;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it2  <= it1;
      c2   <= c1;
      s2   <= s1;
      p_cy <= 66'(cm1) * 66'(it1.dy);
      p_sx <= 66'(y1) * 66'(it1.dx);
      p_sy <= 66'(y1) * 66'(it1.dy);
      p_cx <= 66'(cm1) * 66'(it1.dx);
    end
  end

  // numerator sums
  logic           v3;
  pti_pkg::item_t it3;
  logic signed [17:0] c3, s3;
  logic signed [pti_pkg::NUM_W-1:0] nx3, ny3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it3 <= it2;
      c3  <= c2;
      s3  <= s2;
      nx3 <= pti_pkg::NUM_W'(p_cy) + pti_pkg::NUM_W'(p_sx);
      ny3 <= pti_pkg::NUM_W'(p_sy) - pti_pkg::NUM_W'(p_cx);
    end
  end

  logic signed [pti_pkg::Q30_W-1:0] den3;
  assign den3 = pti_pkg::q30_t'(it3.ang) <<< 14;
  logic [TAG_W-1:0] tag3, tagx, tagy;
  assign tag3 = {it3.zero, c3, s3, it3.dx, it3.dy};

  logic dvx, dvy;
  logic signed [pti_pkg::QUO_W:0] qx, qy;

  // a zero angle feeds a dummy denominator; its quotient is ignored
  pti_divider #(.NUM_W(pti_pkg::NUM_W), .DEN_W(pti_pkg::Q30_W),
    .Q_W(pti_pkg::QUO_W), .TAG_W(TAG_W)) u_div_x (
    .clk, .rst, .en, .in_valid(v3), .num(nx3),
    .den(it3.zero ? pti_pkg::Q30_ONE : den3), .in_tag(tag3),
    .out_valid(dvx), .quo(qx), .out_tag(tagx));
  pti_divider #(.NUM_W(pti_pkg::NUM_W), .DEN_W(pti_pkg::Q30_W),
    .Q_W(pti_pkg::QUO_W), .TAG_W(TAG_W)) u_div_y (
    .clk, .rst, .en, .in_valid(v3), .num(ny3),
    .den(it3.zero ? pti_pkg::Q30_ONE : den3), .in_tag(tag3),
    .out_valid(dvy), .quo(qy), .out_tag(tagy));

  // output register with saturation and the zero-angle bypass
  logic tz;
  logic signed [31:0] tdx, tdy;
  logic signed [17:0] tc, ts;
  assign {tz, tc, ts, tdx, tdy} = tagx;

  function automatic logic signed [31:0] sat32(input logic signed [pti_pkg::QUO_W:0] q);
    logic signed [31:0] r;
    if (q > 37'sd2147483647) r = 32'sh7FFFFFFF;
    else if (q < -37'sd2147483648) r = 32'sh80000000;
    else r = 32'(q);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dvx;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cos_theta <= tz ? 18'sd65536 : tc;
      sin_theta <= tz ? 18'sd0 : ts;
      trans_x   <= tz ? tdx : sat32(qx);
      trans_y   <= tz ? tdy : sat32(qy);
    end
  end

  a_div_lock: assert property (@(posedge clk) disable iff (rst) dvx == dvy)
    else $error("divider lanes out of step");
  a_tag_lock: assert property (@(posedge clk) disable iff (rst) dvx |-> tagx == tagy)
    else $error("divider tags differ");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(trans_x))
    else $error("stalled result lost");
  a_trig: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cos_theta <= 18'sd65536 && cos_theta >= -18'sd65536)
    else $error("cosine out of range");

endmodule

// ===== hw/rtl/pti_divider.sv =====
// pipelined signed restoring divider, one quotient bit a stage, truncation toward zero
module pti_divider #(
  parameter int unsigned NUM_W = 67,
  parameter int unsigned DEN_W = 34,
  parameter int unsigned Q_W = 36,
  parameter int unsigned TAG_W = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_valid,
  output logic signed [Q_W:0]     quo,
  output logic [TAG_W-1:0]        out_tag
);

  // a quotient magnitude of 2^Q_W or more is flagged at the first stage
  // and comes out as the largest magnitude that fits
  localparam int unsigned MW = NUM_W - 1;

  logic [Q_W:0]           v;
  logic [MW-1:0]          rem  [Q_W+1];
  logic [MW-1:0]          nrem [Q_W];
  logic [DEN_W-2:0]       dmag [Q_W+1];
  logic [Q_W-1:0]         qb   [Q_W+1];
  logic                   qneg [Q_W+1];
  logic                   ovf  [Q_W+1];
  logic [TAG_W-1:0]       tag  [Q_W+1];

  logic [NUM_W-1:0] nabs;
  logic [DEN_W-1:0] dabs;
  assign nabs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dabs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Q_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= nabs[MW-1:0];
      dmag[0] <= dabs[DEN_W-2:0];
      qb[0]   <= '0;
      qneg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      ovf[0]  <= 1'b0;
      tag[0]  <= in_tag;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_st
    localparam int unsigned SH = Q_W - 1 - s;
    logic [MW+Q_W:0] dsh;
    logic            ge;
    assign dsh = {{(MW+Q_W+2-DEN_W){1'b0}}, dmag[s]} << SH;
    assign ge  = {{(Q_W+1){1'b0}}, rem[s]} >= dsh;
    assign nrem[s] = ge ? MW'({{(Q_W+1){1'b0}}, rem[s]} - dsh) : rem[s];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= nrem[s];
        dmag[s+1] <= dmag[s];
        qb[s+1]   <= {qb[s][Q_W-2:0], ge};
        qneg[s+1] <= qneg[s];
        tag[s+1]  <= tag[s];
        // any remainder beyond top quotient bit span means overflow
        if (s == 0) begin
          ovf[s+1] <= ({{(Q_W+1){1'b0}}, rem[s]} >= (dsh << 1));
        end else begin
          ovf[s+1] <= ovf[s];
        end
      end
    end
  end

  logic [Q_W:0] qmag;
  assign qmag = ovf[Q_W] ? {1'b0, {Q_W{1'b1}}} : {1'b0, qb[Q_W]};
  assign quo       = qneg[Q_W] ? -$signed(qmag) : $signed(qmag);
  assign out_valid = v[Q_W];
  assign out_tag   = tag[Q_W];

endmodule
